// ----- src/scmp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the shift-chain multichannel PWM driver.
// No dependencies; every other file of the block refers to this package.
package scmp_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAN_W = 7;
  localparam int AMT_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_SET_BIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_DUTY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  localparam logic signed [AMT_W-1:0] DUTY_OFF = -6'sd1;
  localparam int DUTY_LIMIT = 31;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_SET_BIT,
    OP_SET_DUTY,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [CHAN_W-1:0]        chan;
    logic signed [AMT_W-1:0]  value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_LOAD,
    ST_SEND
  } state_t;

endpackage

// ----- src/scmp_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and frame-byte streams.
// Depends on scmp_pkg for field widths.
interface scmp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [scmp_pkg::CMD_W-1:0]           command;
  logic [scmp_pkg::CHAN_W-1:0]          channel;
  logic signed [scmp_pkg::AMT_W-1:0]    amount;

  modport source (output valid, output command, output channel, output amount, input ready);
  modport sink   (input valid, input command, input channel, input amount, output ready);
endinterface

interface scmp_out_if;
  logic                          valid;
  logic                          ready;
  logic [scmp_pkg::BYTE_W-1:0]   frame_byte;
  logic                          last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ----- src/scmp_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts command beats, drops ignored ones, clamps duty values
// and holds decoded commands in a two-entry queue. Depends on scmp_pkg, scmp_ifs.
module scmp_front #(
  parameter int PWM_CHANNELS = 55,
  parameter int PWM_STEPS    = 32,
  parameter int OUTPUT_BITS  = 80
) (
  input  logic                clk,
  input  logic                rst_n,
  scmp_in_if.sink             in_ch,
  output logic                q_valid,
  output scmp_pkg::cmd_t      q_cmd,
  input  logic                q_take
);

  localparam int DUTY_MAX = (PWM_STEPS - 1 < scmp_pkg::DUTY_LIMIT) ?
                            PWM_STEPS - 1 : scmp_pkg::DUTY_LIMIT;

  scmp_pkg::cmd_t                 queue_r [scmp_pkg::QUEUE_DEPTH];
  logic [scmp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [scmp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [scmp_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  scmp_pkg::cmd_t                 dec_cmd;
  logic                           dec_keep;
  logic                           push;
  logic                           pop;

  assign in_ch.ready = (cnt_r != scmp_pkg::QCNT_W'(scmp_pkg::QUEUE_DEPTH));
  assign q_valid     = (cnt_r != '0);
  assign q_cmd       = queue_r[rd_ptr_r];

  always_comb begin
    dec_cmd.op    = scmp_pkg::OP_TICK;
    dec_cmd.chan  = in_ch.channel;
    dec_cmd.value = in_ch.amount;
    dec_keep      = 1'b0;
    unique case (in_ch.command)
      scmp_pkg::CMD_SET_BIT: begin
        dec_cmd.op    = scmp_pkg::OP_SET_BIT;
        dec_cmd.value = (in_ch.amount != '0) ? 6'sd1 : 6'sd0;
        dec_keep      = (int'(in_ch.channel) < OUTPUT_BITS);
      end
      scmp_pkg::CMD_SET_DUTY: begin
        dec_cmd.op = scmp_pkg::OP_SET_DUTY;
        dec_keep   = (int'(in_ch.channel) < PWM_CHANNELS);
        if (int'(in_ch.amount) < -1) begin
          dec_cmd.value = scmp_pkg::DUTY_OFF;
        end else if (int'(in_ch.amount) > DUTY_MAX) begin
          dec_cmd.value = scmp_pkg::AMT_W'(DUTY_MAX);
        end
      end
      scmp_pkg::CMD_TICK: begin
        dec_cmd.op = scmp_pkg::OP_TICK;
        dec_keep   = 1'b1;
      end
      default: begin
        dec_keep = 1'b0;
      end
    endcase
  end

  assign push = in_ch.valid && in_ch.ready && dec_keep;
  assign pop  = q_valid && q_take;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + scmp_pkg::QCNT_W'(push) - scmp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

// ----- src/scmp_back.sv -----
`timescale 1ns / 1ps
// Back end: holds the output bits, duty memory and step counter, walks the
// duty memory on a tick and shifts the frame out byte by byte. Depends on scmp_pkg, scmp_ifs.
module scmp_back #(
  parameter int PWM_CHANNELS = 55,
  parameter int PWM_STEPS    = 32,
  parameter int OUTPUT_BITS  = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  scmp_pkg::cmd_t   q_cmd,
  output logic             q_take,
  scmp_out_if.source       out_ch
);

  localparam int SCAN_N     = (PWM_CHANNELS < OUTPUT_BITS) ? PWM_CHANNELS : OUTPUT_BITS;
  localparam int SIW        = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int DIW        = (PWM_CHANNELS > 1) ? $clog2(PWM_CHANNELS) : 1;
  localparam int BIW        = $clog2(OUTPUT_BITS);
  localparam int SW         = $clog2(PWM_STEPS);
  localparam int CMPW       = (SW > 5) ? SW : 5;
  localparam int BYTE_COUNT = (OUTPUT_BITS + 7) / 8;
  localparam int FRAME_BITS = BYTE_COUNT * scmp_pkg::BYTE_W;
  localparam int BCW        = (BYTE_COUNT > 1) ? $clog2(BYTE_COUNT) : 1;

  scmp_pkg::state_t                   state_r, state_nxt;
  logic [OUTPUT_BITS-1:0]             bits_r;
  logic signed [scmp_pkg::AMT_W-1:0]  duty_mem [PWM_CHANNELS];
  logic [PWM_CHANNELS-1:0]            duty_vld_r;
  logic [SIW-1:0]                     scan_idx_r;
  logic                               rd_pend_r;
  logic                               rd_en_r;
  logic [SIW-1:0]                     rd_idx_r;
  logic signed [scmp_pkg::AMT_W-1:0]  rd_data_r;
  logic [SW-1:0]                      step_r;
  logic [FRAME_BITS-1:0]              frame_r;
  logic [BCW-1:0]                     byte_cnt_r;
  logic                               out_valid_r;
  logic [scmp_pkg::BYTE_W-1:0]        out_byte_r;
  logic                               out_last_r;
  logic                               scan_last;
  logic                               send_last;
  logic                               out_free;
  logic                               send_beat;
  logic                               pwm_level;

  assign q_take           = (state_r == scmp_pkg::ST_IDLE) && q_valid;
  assign scan_last        = (scan_idx_r == SIW'(SCAN_N - 1));
  assign send_last        = (byte_cnt_r == BCW'(BYTE_COUNT - 1));
  assign out_free         = !out_valid_r || out_ch.ready;
  assign send_beat        = (state_r == scmp_pkg::ST_SEND) && out_free;
  assign pwm_level        = (rd_data_r != '0) &&
                            (CMPW'(rd_data_r[scmp_pkg::AMT_W-2:0]) >= CMPW'(step_r));
  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.last_byte  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scmp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scmp_pkg::ST_IDLE: begin
        if (q_take && (q_cmd.op == scmp_pkg::OP_TICK)) begin
          state_nxt = scmp_pkg::ST_SCAN;
        end
      end
      scmp_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = scmp_pkg::ST_SETTLE;
        end
      end
      scmp_pkg::ST_SETTLE: begin
        state_nxt = scmp_pkg::ST_LOAD;
      end
      scmp_pkg::ST_LOAD: begin
        state_nxt = scmp_pkg::ST_SEND;
      end
      scmp_pkg::ST_SEND: begin
        if (out_free && send_last) begin
          state_nxt = scmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scmp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_take && (q_cmd.op == scmp_pkg::OP_SET_DUTY)) begin
      duty_mem[q_cmd.chan[DIW-1:0]] <= q_cmd.value;
    end
    rd_data_r <= duty_mem[DIW'(scan_idx_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= '0;
      duty_vld_r  <= '0;
      step_r      <= '0;
      scan_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      rd_en_r     <= 1'b0;
      rd_idx_r    <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= 1'b0;
      if (q_take && (q_cmd.op == scmp_pkg::OP_SET_BIT)) begin
        bits_r[q_cmd.chan[BIW-1:0]] <= q_cmd.value[0];
      end
      if (q_take && (q_cmd.op == scmp_pkg::OP_SET_DUTY)) begin
        duty_vld_r[q_cmd.chan[DIW-1:0]] <= 1'b1;
      end
      if (q_take) begin
        scan_idx_r <= '0;
      end
      if (state_r == scmp_pkg::ST_SCAN) begin
        rd_pend_r <= 1'b1;
        rd_idx_r  <= scan_idx_r;
        rd_en_r   <= duty_vld_r[DIW'(scan_idx_r)];
        if (!scan_last) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
      if (rd_pend_r && rd_en_r && (rd_data_r != scmp_pkg::DUTY_OFF)) begin
        bits_r[BIW'(rd_idx_r)] <= pwm_level;
      end
      if (state_r == scmp_pkg::ST_LOAD) begin
        byte_cnt_r <= '0;
        step_r     <= (step_r == SW'(PWM_STEPS - 1)) ? '0 : step_r + 1'b1;
      end
      if (send_beat) begin
        out_valid_r <= 1'b1;
        byte_cnt_r  <= byte_cnt_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == scmp_pkg::ST_LOAD) begin
      frame_r <= FRAME_BITS'(bits_r);
    end else if (send_beat) begin
      frame_r <= frame_r << scmp_pkg::BYTE_W;
    end
    if (send_beat) begin
      out_byte_r <= frame_r[FRAME_BITS-1 -: scmp_pkg::BYTE_W];
      out_last_r <= send_last;
    end
  end

endmodule

// ----- src/shift_chain_multichannel_pwm.sv -----
`timescale 1ns / 1ps
// Top level of the shift-chain multichannel PWM driver.
// Depends on scmp_pkg, scmp_ifs, scmp_front and scmp_back.
//
// Usage: commands arrive on in_ch (valid/ready); a beat is taken when both
// are high. Command 0 forces one output bit, command 1 writes one duty entry,
// command 2 is a PWM tick. Only a tick produces beats on out_ch: the frame,
// most significant byte first, with last_byte set on the final byte where the
// chain latch should pulse.
// A set command is absorbed when the idle back end takes it from the queue. A
// tick walks min(PWM_CHANNELS, OUTPUT_BITS) entries of the duty memory, one
// entry per cycle through its single read port, and then sends the frame one
// byte per cycle while the receiver keeps ready high; with the defaults that
// is 55 entries of scan and 10 byte beats.
// A two-entry command queue sits between the front and back ends, so in_ch
// keeps accepting while a frame is being sent.
// Reset clears the output bits, marks every duty entry disabled and zeroes the
// step counter at once; no clearing pass is needed. When the receiver stalls,
// the current byte holds on out_ch and the back end waits; in_ch stalls only
// when the queue is full.
module shift_chain_multichannel_pwm #(
  parameter int PWM_CHANNELS = 55,
  parameter int PWM_STEPS    = 32,
  parameter int OUTPUT_BITS  = 80
) (
  input  logic         clk,
  input  logic         rst_n,
  scmp_in_if.sink      in_ch,
  scmp_out_if.source   out_ch
);

  logic             q_valid;
  logic             q_take;
  scmp_pkg::cmd_t   q_cmd;

  scmp_front #(
    .PWM_CHANNELS (PWM_CHANNELS),
    .PWM_STEPS    (PWM_STEPS),
    .OUTPUT_BITS  (OUTPUT_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_take  (q_take)
  );

  scmp_back #(
    .PWM_CHANNELS (PWM_CHANNELS),
    .PWM_STEPS    (PWM_STEPS),
    .OUTPUT_BITS  (OUTPUT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_take  (q_take),
    .out_ch  (out_ch)
  );

endmodule

// ----- src/scmp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the shift-chain multichannel PWM driver, bound to
// the top level. Depends on scmp_pkg for the command codes.
module scmp_checker #(
  parameter int OUTPUT_BITS = 80
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [scmp_pkg::CMD_W-1:0]    in_command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [scmp_pkg::BYTE_W-1:0]   out_frame_byte,
  input logic                          out_last_byte
);

  localparam int BYTE_COUNT = (OUTPUT_BITS + 7) / 8;
  localparam int BCW        = (BYTE_COUNT > 1) ? $clog2(BYTE_COUNT) : 1;

  logic [BCW-1:0] beat_cnt_r;
  logic [7:0]     ticks_open_r;
  logic           tick_in;
  logic           frame_end;

  assign tick_in   = in_valid && in_ready && (in_command == scmp_pkg::CMD_TICK);
  assign frame_end = out_valid && out_ready && out_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_cnt_r   <= '0;
      ticks_open_r <= '0;
    end else begin
      if (out_valid && out_ready) begin
        beat_cnt_r <= out_last_byte ? '0 : beat_cnt_r + 1'b1;
      end
      ticks_open_r <= ticks_open_r + 8'(tick_in) - 8'(frame_end);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("Block not idle after reset.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) && $stable(out_last_byte))
    else $error("Stalled output beat changed.");

  a_last_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_byte == (beat_cnt_r == BCW'(BYTE_COUNT - 1))))
    else $error("Latch flag not on the final byte of the frame.");

  a_frame_has_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ticks_open_r != '0))
    else $error("Frame byte sent without a pending tick.");

endmodule

bind shift_chain_multichannel_pwm scmp_checker #(
  .OUTPUT_BITS (OUTPUT_BITS)
) u_scmp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_command     (in_ch.command),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_frame_byte (out_ch.frame_byte),
  .out_last_byte  (out_ch.last_byte)
);
